### src/igemm_pkg.sv
package igemm_pkg;

    localparam logic [1:0] MODE_WRITE_A = 2'd0;
    localparam logic [1:0] MODE_WRITE_B = 2'd1;
    localparam logic [1:0] MODE_START   = 2'd2;
    localparam logic [1:0] MODE_READ_C  = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  word_index;
        logic [31:0] data_word;
        logic        clear_first;
    } gemm_cmd_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               gemm_done;
    } gemm_rsp_t;

    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic clear;
        logic rd_issue;
        logic rd_result;
        logic issue;
        logic first;
        logic last;
        logic out_load;
        logic hold_load;
        logic from_hold;
        logic done_bit;
    } dp_ctrl_t;

    typedef struct packed {
        logic busy;
    } dp_status_t;

endpackage

### src/igemm_ctrl.sv
module igemm_ctrl
    import igemm_pkg::*;
#(
    parameter int TILE_DIM = 8,
    localparam int RW = $clog2(TILE_DIM)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  logic [1:0]    cmd_mode,
    input  logic          cmd_clear,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  dp_status_t    status,
    output dp_ctrl_t      ctrl,
    output logic [RW-1:0] row,
    output logic [RW-1:0] k
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDATA = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_HOLD  = 3'd4;

    localparam logic [RW-1:0] LAST_IDX = RW'(TILE_DIM - 1);

    logic [2:0]    state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [RW-1:0] k_reg, k_next;
    logic          rsp_valid_reg, rsp_valid_next;
    logic          done_reg, done_next;
    logic          accept;
    logic          rsp_free;
    logic          fresh;
    logic          drain_done;

    assign accept    = cmd_valid && (state_reg == S_IDLE);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign row       = row_reg;
    assign k         = k_reg;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        k_next     = k_reg;
        ctrl       = '0;
        fresh      = 1'b0;
        drain_done = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_mode)
                        MODE_WRITE_A:
                        begin
                            ctrl.wr_a = 1'b1;
                            fresh     = 1'b1;
                        end
                        MODE_WRITE_B:
                        begin
                            ctrl.wr_b = 1'b1;
                            fresh     = 1'b1;
                        end
                        MODE_START:
                        begin
                            ctrl.clear = cmd_clear;
                            row_next   = '0;
                            k_next     = '0;
                            state_next = S_RUN;
                        end
                        MODE_READ_C:
                        begin
                            ctrl.rd_issue = 1'b1;
                            state_next    = S_RDATA;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RDATA:
            begin
                ctrl.rd_result = 1'b1;
                fresh          = 1'b1;
            end
            S_RUN:
            begin
                ctrl.issue = 1'b1;
                ctrl.first = (k_reg == '0);
                ctrl.last  = (k_reg == LAST_IDX);
                if (k_reg == LAST_IDX)
                begin
                    k_next   = '0;
                    row_next = row_reg + 1'b1;
                    if (row_reg == LAST_IDX)
                    begin
                        state_next = S_DRAIN;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!status.busy)
                begin
                    drain_done = 1'b1;
                    fresh      = 1'b1;
                end
            end
            S_HOLD:
            begin
                if (rsp_free)
                begin
                    ctrl.out_load  = 1'b1;
                    ctrl.from_hold = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished result goes straight out if the output register is free,
        // otherwise it waits in the hold register.
        if (fresh)
        begin
            if (rsp_free)
            begin
                ctrl.out_load = 1'b1;
                state_next    = S_IDLE;
            end
            else
            begin
                ctrl.hold_load = 1'b1;
                state_next     = S_HOLD;
            end
        end

        ctrl.done_bit = done_reg || drain_done;
        done_next     = done_reg || drain_done;

        if (ctrl.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
            done_reg      <= done_next;
        end
    end

endmodule

### src/igemm_datapath.sv
module igemm_datapath
    import igemm_pkg::*;
#(
    parameter int TILE_DIM = 8,
    localparam int RW = $clog2(TILE_DIM)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  gemm_cmd_t     cmd,
    input  dp_ctrl_t      ctrl,
    input  logic [RW-1:0] row,
    input  logic [RW-1:0] k,
    output dp_status_t    status,
    output gemm_rsp_t     rsp
);

    localparam int ELEMS = TILE_DIM * TILE_DIM;

    // Tiles are held unpacked, one row per entry.
    logic [TILE_DIM-1:0][7:0]  a_row_reg [TILE_DIM];
    logic [TILE_DIM-1:0][7:0]  b_row_reg [TILE_DIM];

    logic [7:0]                a_elem_reg;
    logic [TILE_DIM-1:0][7:0]  b_sel_reg;
    logic                      v1_reg, first1_reg, last1_reg;
    logic [RW-1:0]             row1_reg;
    logic                      v2_reg, first2_reg, last2_reg;
    logic [RW-1:0]             row2_reg;
    logic [TILE_DIM-1:0][15:0] prod_reg;
    logic [TILE_DIM-1:0][31:0] acc_reg;
    logic [TILE_DIM-1:0][31:0] base;
    logic                      wb_reg;
    logic [RW-1:0]             wb_row_reg;

    logic [TILE_DIM-1:0][31:0] c_mem [TILE_DIM];
    logic [TILE_DIM-1:0][31:0] c_rdata_reg;
    logic                      c_rvalid_reg;
    logic [TILE_DIM-1:0]       c_valid_reg;
    logic                      c_re;
    logic [RW-1:0]             c_raddr;

    logic [RW-1:0]             rd_row, rd_col, col_reg;
    logic                      in_range, in_range_reg;
    logic signed [31:0]        rd_val;
    gemm_rsp_t                 fresh, hold_reg, rsp_reg;

    // Tile writes: each element knows which packed word and byte lane it comes from.
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < TILE_DIM; r++)
        begin
            for (int c = 0; c < TILE_DIM; c++)
            begin
                if (ctrl.wr_a && (int'(cmd.word_index) == ((r * TILE_DIM + c) >> 2)))
                begin
                    a_row_reg[r][c] <= cmd.data_word[((r * TILE_DIM + c) & 3) * 8 +: 8];
                end
                if (ctrl.wr_b && (int'(cmd.word_index) == ((r * TILE_DIM + c) >> 2)))
                begin
                    b_row_reg[r][c] <= cmd.data_word[((r * TILE_DIM + c) & 3) * 8 +: 8];
                end
            end
        end
    end

    // Row and column of a C element index, found by comparing against row starts.
    always_comb
    begin
        rd_row = '0;
        for (int r = 1; r < TILE_DIM; r++)
        begin
            if (int'(cmd.word_index) >= r * TILE_DIM)
            begin
                rd_row = RW'(r);
            end
        end
        rd_col   = RW'(int'(cmd.word_index) - int'(rd_row) * TILE_DIM);
        in_range = int'(cmd.word_index) < ELEMS;
    end

    assign c_re    = ctrl.rd_issue || (ctrl.issue && ctrl.first);
    assign c_raddr = ctrl.rd_issue ? rd_row : row;

    // C accumulator rows, one write and one read port.
    always_ff @(posedge clk)
    begin
        if (wb_reg)
        begin
            c_mem[wb_row_reg] <= acc_reg;
        end
        if (c_re)
        begin
            c_rdata_reg  <= c_mem[c_raddr];
            c_rvalid_reg <= c_valid_reg[c_raddr];
        end
    end

    // A row that was never written since reset or the last clear reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            c_valid_reg <= '0;
        end
        else if (wb_reg)
        begin
            c_valid_reg[wb_row_reg] <= 1'b1;
        end
    end

    always_comb
    begin
        for (int j = 0; j < TILE_DIM; j++)
        begin
            base[j] = c_rvalid_reg ? c_rdata_reg[j] : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            wb_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.issue;
            v2_reg <= v1_reg;
            wb_reg <= v2_reg && last2_reg;
        end
    end

    // Each cycle one A element is broadcast across the lanes of one B row.
    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            a_elem_reg <= a_row_reg[row][k];
            b_sel_reg  <= b_row_reg[k];
        end
        first1_reg <= ctrl.first;
        last1_reg  <= ctrl.last;
        row1_reg   <= row;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        row2_reg   <= row1_reg;
        wb_row_reg <= row2_reg;
        if (v1_reg)
        begin
            // Both operands are sign-extended to the product width before multiplying.
            for (int j = 0; j < TILE_DIM; j++)
            begin
                prod_reg[j] <= $signed({{8{a_elem_reg[7]}}, a_elem_reg})
                             * $signed({{8{b_sel_reg[j][7]}}, b_sel_reg[j]});
            end
        end
        if (v2_reg)
        begin
            for (int j = 0; j < TILE_DIM; j++)
            begin
                acc_reg[j] <= (first2_reg ? base[j] : acc_reg[j])
                            + 32'($signed(prod_reg[j]));
            end
        end
    end

    assign rd_val = (in_range_reg && c_rvalid_reg) ? $signed(c_rdata_reg[col_reg]) : 32'sd0;

    always_comb
    begin
        fresh.read_value = ctrl.rd_result ? rd_val : 32'sd0;
        fresh.gemm_done  = ctrl.done_bit;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_issue)
        begin
            col_reg      <= rd_col;
            in_range_reg <= in_range;
        end
        if (ctrl.hold_load)
        begin
            hold_reg <= fresh;
        end
        if (ctrl.out_load)
        begin
            rsp_reg <= ctrl.from_hold ? hold_reg : fresh;
        end
    end

    assign status.busy = v1_reg || v2_reg || wb_reg;
    assign rsp         = rsp_reg;

endmodule

### src/int8_tile_gemm_accumulator.sv
// Tile writes: registered response, one item per cycle unless the output stalls.
// C read: the C row is registered, then the response; no new item meanwhile.
// Start: no new item until done; one A element times
// one B row in the TILE_DIM multiplier lanes per cycle, plus the pipeline drain.
// Reset clears control, the done status and the C row valid bits; no clearing pass.
module int8_tile_gemm_accumulator
    import igemm_pkg::*;
#(
    parameter int TILE_DIM = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  gemm_cmd_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output gemm_rsp_t rsp
);

    localparam int RW = $clog2(TILE_DIM);

    dp_ctrl_t      ctrl;
    dp_status_t    status;
    logic [RW-1:0] row;
    logic [RW-1:0] k;

    igemm_ctrl #(
        .TILE_DIM (TILE_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_mode  (cmd.mode),
        .cmd_clear (cmd.clear_first),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .ctrl      (ctrl),
        .row       (row),
        .k         (k)
    );

    igemm_datapath #(
        .TILE_DIM (TILE_DIM)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .ctrl   (ctrl),
        .row    (row),
        .k      (k),
        .status (status),
        .rsp    (rsp)
    );

endmodule

### src/igemm_checker.sv
module igemm_checker
    import igemm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_ready,
    input gemm_cmd_t cmd,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input gemm_rsp_t rsp
);

    logic       seen_done_reg;
    logic [1:0] pend_reg;
    logic       cmd_acc;
    logic       rsp_acc;

    assign cmd_acc = cmd_valid && cmd_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    // Items taken in but not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_done_reg <= 1'b0;
            pend_reg      <= '0;
        end
        else
        begin
            if (rsp_acc && rsp.gemm_done)
            begin
                seen_done_reg <= 1'b1;
            end
            pend_reg <= pend_reg + 2'(cmd_acc) - 2'(rsp_acc);
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && seen_done_reg |-> rsp.gemm_done)
        else $error("done status fell");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc && (cmd.mode == MODE_START) |=> !cmd_ready)
        else $error("ready during a multiply");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("response with no item outstanding");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many items outstanding");

endmodule

bind int8_tile_gemm_accumulator igemm_checker u_igemm_checker (.*);

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import igemm_pkg::*;

    localparam int TILE_DIM    = 8;
    localparam int ELEMS       = TILE_DIM * TILE_DIM;
    localparam int WORDS       = (ELEMS + 3) / 4;
    localparam int PHASE_ITEMS = 100;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 80;

    // Mirror of the tile engine: packed A/B words, the C accumulators and done status.
    class tile_mac_board;
        logic [31:0] a_words [WORDS];
        logic [31:0] b_words [WORDS];
        logic [31:0] c_acc [ELEMS];
        logic        done_seen;
        gemm_rsp_t   expected_rsps [$];
        int          mismatches;
        int          commands;
        int          starts;
        int          reads;
        int          checked;

        function new();
            foreach (a_words[w])
            begin
                a_words[w] = '0;
                b_words[w] = '0;
            end
            foreach (c_acc[e])
                c_acc[e] = '0;
            done_seen  = 1'b0;
            mismatches = 0;
            commands   = 0;
            starts     = 0;
            reads      = 0;
            checked    = 0;
        endfunction

        function void note_command(gemm_cmd_t c);
            gemm_rsp_t         want;
            logic [31:0]       acc;
            logic signed [7:0] a_el;
            logic signed [7:0] b_el;
            int                ea;
            int                eb;
            int                prod;
            want.read_value = '0;
            commands++;
            case (c.mode)
                MODE_WRITE_A:
                begin
                    if (c.word_index < WORDS)
                        a_words[c.word_index] = c.data_word;
                end
                MODE_WRITE_B:
                begin
                    if (c.word_index < WORDS)
                        b_words[c.word_index] = c.data_word;
                end
                MODE_START:
                begin
                    starts++;
                    if (c.clear_first)
                        foreach (c_acc[e])
                            c_acc[e] = '0;
                    for (int i = 0; i < TILE_DIM; i++)
                    begin
                        for (int j = 0; j < TILE_DIM; j++)
                        begin
                            acc = c_acc[i * TILE_DIM + j];
                            for (int k = 0; k < TILE_DIM; k++)
                            begin
                                ea   = i * TILE_DIM + k;
                                eb   = k * TILE_DIM + j;
                                a_el = a_words[ea / 4][(ea % 4) * 8 +: 8];
                                b_el = b_words[eb / 4][(eb % 4) * 8 +: 8];
                                prod = int'(a_el) * int'(b_el);
                                acc  = acc + prod;
                            end
                            c_acc[i * TILE_DIM + j] = acc;
                        end
                    end
                    done_seen = 1'b1;
                end
                default:
                begin
                    reads++;
                    if (c.word_index < ELEMS)
                        want.read_value = c_acc[c.word_index];
                end
            endcase
            want.gemm_done = done_seen;
            expected_rsps.push_back(want);
        endfunction

        function void check_response(gemm_rsp_t got);
            gemm_rsp_t want;
            checked++;
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response with none outstanding: read_value=%0d gemm_done=%0b",
                             got.read_value, got.gemm_done);
                return;
            end
            want = expected_rsps.pop_front();
            if (got.read_value !== want.read_value || got.gemm_done !== want.gemm_done)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response %0d: read_value exp %0d got %0d, gemm_done exp %0b got %0b",
                             checked, want.read_value, got.read_value,
                             want.gemm_done, got.gemm_done);
            end
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n;
    logic          cmd_valid;
    logic          cmd_ready;
    gemm_cmd_t     cmd;
    logic          rsp_valid;
    logic          rsp_ready;
    gemm_rsp_t     rsp;

    int            send_idle_pct;
    int            recv_stall_pct;
    bit            hold_request;
    int            idle_cycles;
    int            send_plan [4]  = '{0, 48, 0, 24};
    int            stall_plan [4] = '{0, 0, 48, 24};
    tile_mac_board board = new();

    int8_tile_gemm_accumulator #(.TILE_DIM(TILE_DIM)) DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic gemm_cmd_t make_cmd(logic [1:0] m, int idx, logic [31:0] d, bit clr);
        gemm_cmd_t c;
        c.mode        = m;
        c.word_index  = 6'(idx);
        c.data_word   = d;
        c.clear_first = clr;
        return c;
    endfunction

    function automatic gemm_cmd_t random_cmd();
        gemm_cmd_t c;
        int        pick;
        pick          = $urandom_range(0, 99);
        c.word_index  = 6'($urandom_range(0, 63));
        c.data_word   = $urandom();
        c.clear_first = 1'($urandom_range(0, 1));
        if (pick < 25)
            c.mode = MODE_WRITE_A;
        else if (pick < 50)
            c.mode = MODE_WRITE_B;
        else if (pick < 60)
            c.mode = MODE_START;
        else
            c.mode = MODE_READ_C;
        // Tile writes mostly land in range; the rest must be ignored.
        if ((c.mode == MODE_WRITE_A || c.mode == MODE_WRITE_B) && $urandom_range(0, 9) != 0)
            c.word_index = 6'($urandom_range(0, WORDS - 1));
        case ($urandom_range(0, 11))
            0: c.data_word = 32'h8080_8080;
            1: c.data_word = 32'h7F7F_7F7F;
            2: c.data_word = 32'hFFFF_FFFF;
            3: c.data_word = 32'h0000_0000;
            default: ;
        endcase
        return c;
    endfunction

    task automatic send_cmd(input gemm_cmd_t c);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        board.note_command(c);
    endtask

    // Response side: random back-pressure, or one long hold-off when asked.
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            board.check_response(rsp);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("ERROR: no handshake for %0d cycles, %0d responses outstanding",
                         STALL_LIMIT, board.expected_rsps.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        cmd_valid      = 1'b0;
        cmd            = '0;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        idle_cycles    = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reads before any start give zero with the done status still low.
        send_cmd(make_cmd(MODE_READ_C, 0, 32'hFFFF_FFFF, 1'b1));
        send_cmd(make_cmd(MODE_READ_C, ELEMS - 1, 32'h0000_0000, 1'b0));
        send_cmd(make_cmd(MODE_WRITE_A, WORDS, 32'h1234_5678, 1'b1));
        send_cmd(make_cmd(MODE_WRITE_B, 63, 32'hFFFF_FFFF, 1'b1));

        // Every tile word is written before the first start.
        for (int w = 0; w < WORDS; w++)
        begin
            send_cmd(make_cmd(MODE_WRITE_A, w, 32'h8080_8080, w[0]));
            send_cmd(make_cmd(MODE_WRITE_B, w, 32'h8080_8080, w[1]));
        end

        send_cmd(make_cmd(MODE_START, 63, 32'hFFFF_FFFF, 1'b1));
        send_cmd(make_cmd(MODE_READ_C, 0, 32'hA5A5_A5A5, 1'b1));
        send_cmd(make_cmd(MODE_READ_C, ELEMS - 1, 32'h0, 1'b0));
        send_cmd(make_cmd(MODE_START, 0, 32'h0, 1'b0));
        send_cmd(make_cmd(MODE_READ_C, 27, 32'h0, 1'b0));
        send_cmd(make_cmd(MODE_WRITE_A, 0, 32'h7F7F_7F7F, 1'b0));
        send_cmd(make_cmd(MODE_WRITE_B, 0, 32'h7F80_7F80, 1'b1));
        send_cmd(make_cmd(MODE_WRITE_A, WORDS - 1, 32'h0000_0000, 1'b1));
        send_cmd(make_cmd(MODE_WRITE_B, WORDS - 1, 32'hFFFF_FFFF, 1'b0));
        send_cmd(make_cmd(MODE_START, 42, 32'h5A5A_5A5A, 1'b1));
        send_cmd(make_cmd(MODE_START, 0, 32'h0, 1'b0));
        send_cmd(make_cmd(MODE_READ_C, 1, 32'h0, 1'b1));
        send_cmd(make_cmd(MODE_READ_C, ELEMS - 2, 32'h0, 1'b0));
        send_cmd(make_cmd(MODE_WRITE_A, 63, 32'hFFFF_FFFF, 1'b0));
        send_cmd(make_cmd(MODE_READ_C, ELEMS - 1, 32'h0, 1'b0));

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_plan[p];
            recv_stall_pct = stall_plan[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // With the sender at full rate, a long hold-off backs the block up.
                if (p == 0 && n == 10)
                    hold_request = 1'b1;
                send_cmd(random_cmd());
            end
        end

        @(negedge clk);
        cmd_valid <= 1'b0;
        while (board.expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Run covered %0d items (%0d tile starts, %0d C reads), %0d responses checked.",
                 board.commands, board.starts, board.reads, board.checked);
        $display("Idling mixes: none, sender only, receiver only, both; one %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (board.mismatches == 0)
            $display("[ OK ] regression clean");
        else
        begin
            $display("%0d mismatches in total", board.mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
